/* sv/bzc_pkg.sv */
// shared types, constants and the byte table for the buzhash chunker
`timescale 1ns / 1ps
`default_nettype none

package bzc_pkg;

    // field widths
    localparam int BYTE_BITS      = 8;
    localparam int HASH_BITS      = 64;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CMP_BITS       = 32;
    localparam int TABLE_ENTRIES  = 256;

    // defaults for the top level parameters
    localparam int WINDOW_LEN_DEF = 64;
    localparam int COUNT_BITS_DEF = 24;

    // configuration reset values
    localparam logic [CFG_DATA_BITS-1:0] MIN_CHUNK_RST = 24'd2048;
    localparam logic [CFG_DATA_BITS-1:0] AVG_MASK_RST  = 24'd8191;
    localparam logic [CFG_DATA_BITS-1:0] MAX_CHUNK_RST = 24'd65536;

    // splitmix64 constants
    localparam logic [HASH_BITS-1:0] SM_SEED  = 64'hD6E8FEB86659FD93;
    localparam logic [HASH_BITS-1:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [HASH_BITS-1:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [HASH_BITS-1:0] SM_MUL2  = 64'h94D049BB133111EB;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_CHUNK = 2'd0,
        CFG_AVG_MASK  = 2'd1,
        CFG_MAX_CHUNK = 2'd2
    } t_cfg_index;

    // one result item
    typedef struct packed {
        logic                     cut_here;
        logic [CFG_DATA_BITS-1:0] chunk_length;
        logic [HASH_BITS-1:0]     rolling_hash;
    } t_result;

    typedef logic [HASH_BITS-1:0] t_table [TABLE_ENTRIES];

    // table contents, evaluated at elaboration only
    function automatic t_table build_table();
        t_table               tbl;
        logic [HASH_BITS-1:0] s;
        logic [HASH_BITS-1:0] z;
        s = SM_SEED;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            s = s + SM_GAMMA;
            z = s;
            z = (z ^ (z >> 30)) * SM_MUL1;
            z = (z ^ (z >> 27)) * SM_MUL2;
            tbl[i] = z ^ (z >> 31);
        end
        return tbl;
    endfunction

    localparam t_table BYTE_TABLE = build_table();

endpackage

`default_nettype wire

/* sv/bzc_window_ram.sv */
// window byte memory, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module bzc_window_ram #(
    parameter int DEPTH = bzc_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire logic [bzc_pkg::BYTE_BITS-1:0] i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic      [bzc_pkg::BYTE_BITS-1:0] o_rdata
);

    logic [bzc_pkg::BYTE_BITS-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/bzc_out_skid.sv */
// output register with skid entry so the core keeps taking items under stall
`timescale 1ns / 1ps
`default_nettype none

module bzc_out_skid (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bzc_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output bzc_pkg::t_result      o_data,
    input  wire logic             i_stall
);

    logic             r_out_valid;
    logic             r_skid_valid;
    bzc_pkg::t_result r_out;
    bzc_pkg::t_result r_skid;
    logic             w_take;

    assign w_take  = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid) begin
            r_skid_valid <= r_skid_valid || i_push;
        end else begin
            r_out_valid <= i_push;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (r_out_valid) begin
            if (i_push) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            r_out <= i_data;
        end
    end

endmodule

`default_nettype wire

/* sv/buzhash_chunk_boundary_core.sv */
// buzhash content-defined chunker top level
// Takes one byte per cycle while input stall is low and returns one registered result
// item per byte. The rolling hash update (rotate, table lookups, xor) and the cut
// decision finish in the cycle the byte is taken; the byte leaving the window comes
// from the window memory, whose read of the next slot is issued in the cycle before,
// so the memory's single read port sets no limit on the rate. An output register plus
// a skid entry let the core take a byte while a result waits; input stall rises only
// when both hold results. A cut clears hash, window fill and count for the next byte.
`timescale 1ns / 1ps
`default_nettype none

module buzhash_chunk_boundary_core #(
    parameter int WINDOW_LEN = bzc_pkg::WINDOW_LEN_DEF,
    parameter int COUNT_BITS = bzc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // byte input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [bzc_pkg::BYTE_BITS-1:0]      i_data_byte,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_cut_here,
    output logic      [bzc_pkg::CFG_DATA_BITS-1:0]  o_chunk_length,
    output logic      [bzc_pkg::HASH_BITS-1:0]      o_rolling_hash,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bzc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [bzc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int IDX_BITS  = $clog2(WINDOW_LEN);
    localparam int FILL_BITS = $clog2(WINDOW_LEN + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // state
    logic [bzc_pkg::HASH_BITS-1:0]     r_hash, n_hash;
    logic [IDX_BITS-1:0]               r_index, n_index;
    logic [FILL_BITS-1:0]              r_fill, n_fill;
    logic [COUNT_BITS-1:0]             r_count, n_count;
    logic [bzc_pkg::CFG_DATA_BITS-1:0] r_min_chunk, r_avg_mask, r_max_chunk;

    logic                              w_accept;
    logic                              w_full;
    logic [IDX_BITS-1:0]               w_pos_inc;
    logic [IDX_BITS-1:0]               w_raddr;
    logic [bzc_pkg::BYTE_BITS-1:0]     w_old_byte;
    logic [bzc_pkg::HASH_BITS-1:0]     w_hash;
    logic [bzc_pkg::HASH_BITS-1:0]     w_leave_word;
    logic [COUNT_BITS-1:0]             w_count;
    logic [bzc_pkg::CMP_BITS-1:0]      w_count_cmp;
    logic                              w_cut;
    bzc_pkg::t_result                  w_result;
    bzc_pkg::t_result                  w_out;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_chunk <= bzc_pkg::MIN_CHUNK_RST;
            r_avg_mask  <= bzc_pkg::AVG_MASK_RST;
            r_max_chunk <= bzc_pkg::MAX_CHUNK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bzc_pkg::t_cfg_index'(i_cfg_index))
                bzc_pkg::CFG_MIN_CHUNK: r_min_chunk <= i_cfg_data;
                bzc_pkg::CFG_AVG_MASK:  r_avg_mask  <= i_cfg_data;
                bzc_pkg::CFG_MAX_CHUNK: r_max_chunk <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window slot after the current one
    assign w_pos_inc = (r_index == IDX_BITS'(WINDOW_LEN - 1)) ? '0 : r_index + 1'b1;

    // prefetch the slot the next byte will replace
    assign w_raddr = w_accept ? w_pos_inc : r_index;

    bzc_window_ram #(
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_index),
        .i_wdata (i_data_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_old_byte)
    );

    // hash update and cut decision
    always_comb begin
        w_full       = (r_fill == FILL_BITS'(WINDOW_LEN));
        w_leave_word = w_full ? bzc_pkg::BYTE_TABLE[w_old_byte] : '0;
        w_hash       = {r_hash[bzc_pkg::HASH_BITS-2:0], r_hash[bzc_pkg::HASH_BITS-1]}
                       ^ bzc_pkg::BYTE_TABLE[i_data_byte] ^ w_leave_word;
        w_count      = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        w_count_cmp  = bzc_pkg::CMP_BITS'(w_count);
        w_cut        = (w_count_cmp >= bzc_pkg::CMP_BITS'(r_max_chunk))
                       || ((w_count_cmp >= bzc_pkg::CMP_BITS'(r_min_chunk))
                           && ((w_hash[bzc_pkg::CFG_DATA_BITS-1:0] & r_avg_mask) == '0));

        w_result.cut_here     = w_cut;
        w_result.chunk_length = w_count_cmp[bzc_pkg::CFG_DATA_BITS-1:0];
        w_result.rolling_hash = w_hash;
    end

    // next chunk state
    always_comb begin
        n_hash  = r_hash;
        n_index = r_index;
        n_fill  = r_fill;
        n_count = r_count;
        if (w_accept) begin
            if (w_cut) begin
                n_hash  = '0;
                n_index = '0;
                n_fill  = '0;
                n_count = '0;
            end else begin
                n_hash  = w_hash;
                n_index = w_pos_inc;
                n_fill  = w_full ? r_fill : r_fill + 1'b1;
                n_count = w_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_index <= '0;
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_hash  <= n_hash;
            r_index <= n_index;
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

    // result buffering
    bzc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .i_stall (i_out_stall)
    );

    assign o_cut_here     = w_out.cut_here;
    assign o_chunk_length = w_out.chunk_length;
    assign o_rolling_hash = w_out.rolling_hash;

endmodule

`default_nettype wire

/* sv/bzc_checker.sv */
// port-level checks for the buzhash chunker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bzc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_stall,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire logic                               o_cut_here,
    input wire logic [bzc_pkg::CFG_DATA_BITS-1:0]  o_chunk_length,
    input wire logic [bzc_pkg::HASH_BITS-1:0]      o_rolling_hash
);

    // reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result buffer not empty after reset");

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cut_here)
            && $stable(o_chunk_length) && $stable(o_rolling_hash))
        else $error("stalled result changed");

    // input stall only while results are waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // stall rises only after an item was taken
    a_stall_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stall rose without an item");

    // every chunk holds at least the current byte
    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_chunk_length != '0)
        else $error("zero chunk length reported");

endmodule

bind buzhash_chunk_boundary_core bzc_checker u_bzc_checker (.*);

`default_nettype wire

/* tb/buzhash_chunk_boundary_core_test.sv */
// self-checking testbench for the buzhash chunk boundary core
`timescale 1ns / 1ps

module buzhash_chunk_boundary_core_test;

    localparam int CLK_PERIOD  = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [bzc_pkg::CFG_DATA_BITS-1:0] CNT_TOP = '1;

    // dut ports
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_stall;
    logic [bzc_pkg::BYTE_BITS-1:0]      i_data_byte = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic                               o_cut_here;
    logic [bzc_pkg::CFG_DATA_BITS-1:0]  o_chunk_length;
    logic [bzc_pkg::HASH_BITS-1:0]      o_rolling_hash;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [bzc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [bzc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    // stimulus and scoreboard state
    logic [bzc_pkg::BYTE_BITS-1:0] byte_backlog [$];
    bzc_pkg::t_result              pending_results [$];
    int                            bytes_owed  = 0;
    int                            errors      = 0;
    int                            quiet_cycles = 0;
    int                            src_gap     = 0;
    int                            snk_gap     = 0;
    logic                          src_idle_on = 1'b0;
    logic                          snk_idle_on = 1'b0;
    logic                          byte_fire   = 1'b0;

    // predictor state
    logic [bzc_pkg::HASH_BITS-1:0]     byte_tbl [bzc_pkg::TABLE_ENTRIES];
    logic [bzc_pkg::HASH_BITS-1:0]     roll_hash = '0;
    logic [bzc_pkg::BYTE_BITS-1:0]     win_mem [bzc_pkg::WINDOW_LEN_DEF];
    logic [5:0]                        win_pos   = '0;
    int                                win_fill  = 0;
    logic [bzc_pkg::CFG_DATA_BITS-1:0] chunk_cnt = '0;
    logic [bzc_pkg::CFG_DATA_BITS-1:0] min_len   = bzc_pkg::MIN_CHUNK_RST;
    logic [bzc_pkg::CFG_DATA_BITS-1:0] cut_mask  = bzc_pkg::AVG_MASK_RST;
    logic [bzc_pkg::CFG_DATA_BITS-1:0] max_len   = bzc_pkg::MAX_CHUNK_RST;

    buzhash_chunk_boundary_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cut_here     (o_cut_here),
        .o_chunk_length (o_chunk_length),
        .o_rolling_hash (o_rolling_hash),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // rolls the hash by one byte and decides the cut, clearing the chunk after a cut
    function automatic bzc_pkg::t_result chunker_step(
        input logic [bzc_pkg::BYTE_BITS-1:0] b);
        bzc_pkg::t_result              r;
        logic [bzc_pkg::HASH_BITS-1:0] h;
        h = {roll_hash[bzc_pkg::HASH_BITS-2:0], roll_hash[bzc_pkg::HASH_BITS-1]}
            ^ byte_tbl[b];
        if (win_fill >= bzc_pkg::WINDOW_LEN_DEF) begin
            h = h ^ byte_tbl[win_mem[win_pos]];
        end else begin
            win_fill = win_fill + 1;
        end
        roll_hash        = h;
        win_mem[win_pos] = b;
        win_pos          = win_pos + 1'b1;
        if (chunk_cnt != CNT_TOP) begin
            chunk_cnt = chunk_cnt + 1'b1;
        end
        r.cut_here     = (chunk_cnt >= max_len) ||
                         (chunk_cnt >= min_len
                          && (h[bzc_pkg::CFG_DATA_BITS-1:0] & cut_mask) == '0);
        r.chunk_length = chunk_cnt;
        r.rolling_hash = h;
        // window slots are rewritten before they are read again, so no clear needed
        if (r.cut_here) begin
            roll_hash = '0;
            win_pos   = '0;
            win_fill  = 0;
            chunk_cnt = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors = errors + 1;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    function automatic void queue_byte(input logic [bzc_pkg::BYTE_BITS-1:0] b);
        byte_backlog.push_back(b);
        bytes_owed = bytes_owed + 1;
    endfunction

    // wait until every byte is taken and every result has come back
    task automatic drain();
        do @(negedge i_clk);
        while (bytes_owed != 0 || pending_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input bzc_pkg::t_cfg_index idx,
                             input logic [bzc_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input logic [bzc_pkg::CFG_DATA_BITS-1:0] lo,
                              input logic [bzc_pkg::CFG_DATA_BITS-1:0] mask,
                              input logic [bzc_pkg::CFG_DATA_BITS-1:0] hi);
        drain();
        write_reg(bzc_pkg::CFG_MIN_CHUNK, lo);
        write_reg(bzc_pkg::CFG_AVG_MASK, mask);
        write_reg(bzc_pkg::CFG_MAX_CHUNK, hi);
    endtask

    // random bytes mixed with runs of one repeated byte
    task automatic random_bytes(input int count);
        int                            n;
        int                            run;
        logic [bzc_pkg::BYTE_BITS-1:0] b;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 4) == 0) begin
                run = $urandom_range(1, 80);
                b   = 8'($urandom);
                for (int k = 0; k < run && n < count; k++) begin
                    queue_byte(b);
                    n = n + 1;
                end
            end else begin
                queue_byte(8'($urandom));
                n = n + 1;
            end
        end
        drain();
    endtask

    // byte driver: holds an item until it is taken, with random gaps
    always @(negedge i_clk) begin : byte_driver
        logic hold;
        hold = i_in_valid && !byte_fire;
        if (!hold) begin
            if (src_gap != 0) begin
                src_gap = src_gap - 1;
                i_in_valid <= 1'b0;
            end else if (src_idle_on && $urandom_range(0, 3) == 0) begin
                src_gap = $urandom_range(0, 4);
                i_in_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_data_byte <= byte_backlog.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall bursts
    always @(negedge i_clk) begin
        if (snk_gap != 0) begin
            snk_gap = snk_gap - 1;
            i_out_stall <= 1'b1;
        end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
            snk_gap = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: tracks register writes, predicts each taken byte, checks each result
    always @(posedge i_clk) begin : result_monitor
        bzc_pkg::t_result want;
        byte_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (bzc_pkg::t_cfg_index'(i_cfg_index))
                    bzc_pkg::CFG_MIN_CHUNK: min_len = i_cfg_data;
                    bzc_pkg::CFG_AVG_MASK:  cut_mask = i_cfg_data;
                    bzc_pkg::CFG_MAX_CHUNK: max_len = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                pending_results.push_back(chunker_step(i_data_byte));
                bytes_owed = bytes_owed - 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected item hash", o_rolling_hash, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_cut_here !== want.cut_here) begin
                        report_mismatch("cut_here", 64'(o_cut_here), 64'(want.cut_here));
                    end
                    if (o_chunk_length !== want.chunk_length) begin
                        report_mismatch("chunk_length", 64'(o_chunk_length),
                                        64'(want.chunk_length));
                    end
                    if (o_rolling_hash !== want.rolling_hash) begin
                        report_mismatch("rolling_hash", o_rolling_hash, want.rolling_hash);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [bzc_pkg::HASH_BITS-1:0] seed;
        logic [bzc_pkg::HASH_BITS-1:0] mix;
        // byte table: splitmix64 sequence
        seed = bzc_pkg::SM_SEED;
        for (int k = 0; k < bzc_pkg::TABLE_ENTRIES; k++) begin
            seed        = seed + bzc_pkg::SM_GAMMA;
            mix         = seed;
            mix         = (mix ^ (mix >> 30)) * bzc_pkg::SM_MUL1;
            mix         = (mix ^ (mix >> 27)) * bzc_pkg::SM_MUL2;
            byte_tbl[k] = mix ^ (mix >> 31);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;

        // extreme bytes under the reset limits
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h01);
        queue_byte(8'h80);
        queue_byte(8'h55);
        queue_byte(8'hAA);

        // zero minimum with zero mask: every byte ends a chunk
        set_limits('0, '0, CNT_TOP);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h3C);
        queue_byte(8'hC3);

        // zero maximum, below its range: every byte is a forced cut
        set_limits(CNT_TOP, CNT_TOP, '0);
        queue_byte(8'h7E);
        queue_byte(8'h81);
        queue_byte(8'h00);

        // maximum of one
        set_limits(CNT_TOP, '0, 24'd1);
        queue_byte(8'h0F);
        queue_byte(8'hF0);
        queue_byte(8'hFF);

        // hash cuts from the first byte on
        set_limits('0, 24'h00000F, CNT_TOP);
        random_bytes(80);

        // window fills before any cut is allowed
        set_limits(24'd100, 24'h00003F, 24'd200);
        random_bytes(120);

        // only forced cuts, stalls on the result side only
        snk_idle_on = 1'b1;
        src_idle_on = 1'b0;
        set_limits(CNT_TOP, '0, 24'd70);
        random_bytes(70);

        // full mask, gaps on the byte side only
        src_idle_on = 1'b1;
        snk_idle_on = 1'b0;
        set_limits('0, CNT_TOP, 24'd50);
        random_bytes(50);

        // back to the reset limits
        snk_idle_on = 1'b1;
        set_limits(bzc_pkg::MIN_CHUNK_RST, bzc_pkg::AVG_MASK_RST, bzc_pkg::MAX_CHUNK_RST);
        random_bytes(60);

        // closing stretch at full rate
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        set_limits(24'd5, 24'h000007, 24'd40);
        random_bytes(70);

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
